FILE: hdl/assert_macros.svh
// Assertion macros shared by the journal RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is asserted.
`define CEJ_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property checked at every edge, reset included.
`define CEJ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CEJ_ASSERT(lbl, clk, rstn, prop, msg)
`define CEJ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: hdl/cej_pkg.sv
// Shared types, constants and operation codes of the event journal.
package cej_pkg;

	localparam int DEPTH       = 256;
	localparam int ENTRY_BITS  = 32;
	localparam int PTR_BITS    = 8;
	localparam int CNT_BITS    = 9;
	localparam int OP_BITS     = 2;
	localparam int OFFSET_BITS = 8;

	localparam logic [OP_BITS-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
	localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

	// RAM access issued by the ring control
	typedef struct packed {
		logic                wr_en;
		logic                rd_en;
		logic [PTR_BITS-1:0] addr;
	} cej_mem_req_t;

	// Result fields known at accept time
	typedef struct packed {
		logic                found;
		logic [CNT_BITS-1:0] count;
		logic [PTR_BITS-1:0] newest;
	} cej_res_t;

endpackage

FILE: hdl/circular_event_journal_core.sv
// Circular event journal: ring of entries that overwrites the oldest once full.
// One operation (write, read back from newest, clear) per s_* beat and one result
// per m_* beat. Sustained rate is one beat per cycle while m_tready is high and no
// capacity write is offered; a result passes the single-port entry RAM's registered
// read and then the output register. One further input is taken while a result waits
// in the output register. Capacity is written on the cfg channel, always ready; the
// input is held off in a cycle where a capacity write is offered. Write it only while
// idle and clear the journal afterwards. The entry RAM has no reset and needs no
// clearing pass: reset empties the journal at once.
module circular_event_journal_core #(
	parameter int ENTRY_BITS = cej_pkg::ENTRY_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cej_pkg::CNT_BITS-1:0]         cfg_data,   // capacity
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// entry_data, back_offset
	input  logic [((ENTRY_BITS+cej_pkg::OFFSET_BITS+7)/8)*8-1:0] s_tdata,
	input  logic [cej_pkg::OP_BITS-1:0]          s_tuser,    // operation
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// read_data, entry_count, newest_position
	output logic [((ENTRY_BITS+cej_pkg::CNT_BITS+cej_pkg::PTR_BITS+7)/8)*8-1:0] m_tdata,
	output logic                                 m_tuser     // found
);
	import cej_pkg::*;

	localparam int MW = ((ENTRY_BITS + CNT_BITS + PTR_BITS + 7) / 8) * 8;

	cej_mem_req_t          mem_req;
	cej_res_t              res;
	logic [ENTRY_BITS-1:0] rdata;
	logic                  accept;
	logic                  adv2;

	logic                  valid_s1;
	cej_res_t              res_s1;
	logic                  valid_s2;
	cej_res_t              res_s2;
	logic [ENTRY_BITS-1:0] data_s2;

	assign cfg_ready = 1'b1;
	assign adv2      = !valid_s2 || m_tready;
	// a capacity write takes the cycle, so it never meets an operation
	assign s_tready  = (!valid_s1 || adv2) && !cfg_valid;
	assign accept    = s_tvalid && s_tready;

	cej_ring_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.op        (s_tuser),
		.offset    (s_tdata[ENTRY_BITS +: OFFSET_BITS]),
		.mem_req   (mem_req),
		.res       (res)
	);

	cej_entry_ram #(
		.ENTRY_BITS (ENTRY_BITS)
	) u_ram (
		.clk   (clk),
		.req   (mem_req),
		.wdata (s_tdata[ENTRY_BITS-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			else if (adv2)
				valid_s1 <= 1'b0;
			if (adv2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_s1 <= res;
		if (adv2) begin
			res_s2  <= res_s1;
			data_s2 <= res_s1.found ? rdata : '0;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.found;
	assign m_tdata  = MW'({res_s2.newest, res_s2.count, data_s2});

`include "assert_macros.svh"

	// RAM output must hold while its beat waits in stage 1
	`CEJ_ASSERT(a_rdata_hold, clk, arst_n, (valid_s1 && !adv2) |=> $stable(rdata),
		"read data lost under stall")
	`CEJ_ASSERT(a_full_stall, clk, arst_n, (valid_s1 && valid_s2 && !m_tready) |-> !s_tready,
		"input taken with both stages full")
	`CEJ_ASSERT(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)),
		"result changed while waiting")

endmodule

FILE: hdl/cej_ring_ctrl.sv
// Ring control: capacity register, newest pointer, entry count and slot mapping.
module cej_ring_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [cej_pkg::CNT_BITS-1:0]    cfg_data,
	input  logic                            accept,
	input  logic [cej_pkg::OP_BITS-1:0]     op,
	input  logic [cej_pkg::OFFSET_BITS-1:0] offset,
	output cej_pkg::cej_mem_req_t           mem_req,
	output cej_pkg::cej_res_t               res
);
	import cej_pkg::*;

	localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(DEPTH);

	logic [CNT_BITS-1:0] capacity_q;
	logic [PTR_BITS-1:0] newest_q;
	logic [CNT_BITS-1:0] count_q;

	logic [CNT_BITS-1:0] cap_eff;
	logic [CNT_BITS-1:0] cfg_cap;
	logic [CNT_BITS-1:0] newest9;
	logic [CNT_BITS-1:0] newest_inc;
	logic [CNT_BITS-1:0] off9;
	logic [CNT_BITS-1:0] rd_idx9;
	logic [PTR_BITS-1:0] wr_slot;
	logic                hit;
	logic [PTR_BITS-1:0] newest_d;
	logic [CNT_BITS-1:0] count_d;

	function automatic logic [CNT_BITS-1:0] clamp_cap(input logic [CNT_BITS-1:0] v);
		logic [CNT_BITS-1:0] r;
		r = v;
		if (v == '0)
			r = CNT_BITS'(1);
		else if (v > DEPTH_C)
			r = DEPTH_C;
		return r;
	endfunction

	assign cap_eff    = clamp_cap(capacity_q);
	assign cfg_cap    = clamp_cap(cfg_data);
	assign newest9    = {1'b0, newest_q};
	assign newest_inc = newest9 + CNT_BITS'(1);
	assign wr_slot    = (newest_inc >= cap_eff) ? '0 : newest_inc[PTR_BITS-1:0];
	assign off9       = {1'b0, offset};
	assign hit        = off9 < count_q;
	// read slot wraps past zero to the top of the active ring
	assign rd_idx9    = (newest9 >= off9) ? (newest9 - off9) : (cap_eff - (off9 - newest9));

	always_comb begin
		newest_d       = newest_q;
		count_d        = count_q;
		mem_req.wr_en  = 1'b0;
		mem_req.rd_en  = 1'b0;
		mem_req.addr   = wr_slot;
		res.found      = 1'b0;
		unique case (op)
			OP_WRITE: begin
				newest_d      = wr_slot;
				if (count_q < cap_eff)
					count_d = count_q + CNT_BITS'(1);
				mem_req.wr_en = accept;
			end
			OP_READ: begin
				mem_req.addr  = rd_idx9[PTR_BITS-1:0];
				mem_req.rd_en = accept && hit;
				res.found     = hit;
			end
			OP_CLEAR: begin
				newest_d = '0;
				count_d  = '0;
			end
			default: begin
			end
		endcase
		res.count  = count_d;
		res.newest = newest_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= DEPTH_C;
			newest_q   <= '0;
			count_q    <= '0;
		end else if (accept) begin
			newest_q <= newest_d;
			count_q  <= count_d;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
			if (count_q > cfg_cap)
				count_q <= cfg_cap;
			if (newest9 >= cfg_cap)
				newest_q <= '0;
		end
	end

`include "assert_macros.svh"

	`CEJ_ASSERT(a_count_in_cap, clk, arst_n, count_q <= cap_eff, "count above capacity")
	`CEJ_ASSERT(a_newest_in_cap, clk, arst_n, newest9 < cap_eff, "newest slot outside ring")
	`CEJ_ASSERT(a_write_counts, clk, arst_n, (accept && op == OP_WRITE) |=> (count_q != '0),
		"write left journal empty")

endmodule

FILE: hdl/cej_entry_ram.sv
// Single-port entry RAM with registered read data.
module cej_entry_ram #(
	parameter int ENTRY_BITS = cej_pkg::ENTRY_BITS
) (
	input  logic                  clk,
	input  cej_pkg::cej_mem_req_t req,
	input  logic [ENTRY_BITS-1:0] wdata,
	output logic [ENTRY_BITS-1:0] rdata
);
	import cej_pkg::*;

	logic [ENTRY_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.addr] <= wdata;
		if (req.rd_en)
			rdata <= mem[req.addr];
	end

endmodule
